[rtl/core/mdrf_pkg.sv]
// ----------------------------------------------------------------------------
// mdrf_pkg
// Shared types and constants for the nine-bit multidrop receive framer.
// ----------------------------------------------------------------------------
`default_nettype none

package mdrf_pkg;

	typedef enum logic [1:0] {
		OP_RX_BYTE  = 2'd0,
		OP_TX_DONE  = 2'd1,
		OP_HOST_TX  = 2'd2,
		OP_NOP      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		FS_IDLE   = 2'd0,
		FS_DATA   = 2'd1,
		FS_QUOTED = 2'd2,
		FS_DELIM  = 2'd3
	} frame_state_t;

	localparam logic [7:0] BCAST_ADDR     = 8'h90;
	localparam logic [7:0] SUM_MASK       = 8'h7F;
	localparam logic [7:0] ACK_GOOD       = 8'h80;
	localparam logic [7:0] ACK_BAD        = 8'h81;
	localparam logic [7:0] QUOTE_CH       = 8'h22;
	localparam logic [1:0] TOGGLE_Q       = 2'h3;
	localparam logic [7:0] OWN_ADDR_RESET = 8'hF5;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_DOLL  = 8'h24;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_QMARK = 8'h3F;

	typedef struct packed {
		op_t        operation;
		logic [7:0] rx_byte;
		logic       ninth_bit;
		logic       tx_busy;
	} item_t;

	typedef struct packed {
		logic       store_valid;
		logic [7:0] store_byte;
		logic       send_valid;
		logic [7:0] send_byte;
		logic       listening;
		logic       tx_empty;
	} result_t;

	function automatic logic is_delimiter(input logic [7:0] c);
		logic d;
		case (c) inside
			CH_LF, CH_CR, CH_BANG, CH_DOLL, CH_SEMI, CH_QMARK: d = 1'b1;
			default: d = 1'b0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

[rtl/core/mdrf_if.sv]
// ----------------------------------------------------------------------------
// mdrf_if
// Valid/ready channels for input words and result words of the framer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdrf_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] rx_byte;
	logic       ninth_bit;
	logic       tx_busy;

	modport source (output valid, output operation, output rx_byte, output ninth_bit,
		output tx_busy, input ready);
	modport sink (input valid, input operation, input rx_byte, input ninth_bit,
		input tx_busy, output ready);
endinterface

interface mdrf_result_if;
	logic       valid;
	logic       ready;
	logic       store_valid;
	logic [7:0] store_byte;
	logic       send_valid;
	logic [7:0] send_byte;
	logic       listening;
	logic       tx_empty;

	modport source (output valid, output store_valid, output store_byte,
		output send_valid, output send_byte, output listening, output tx_empty,
		input ready);
	modport sink (input valid, input store_valid, input store_byte,
		input send_valid, input send_byte, input listening, input tx_empty,
		output ready);
endinterface

`default_nettype wire

[rtl/core/multidrop_receive_framer.sv]
// ----------------------------------------------------------------------------
// multidrop_receive_framer
// Receive framer of a nine-bit multidrop UART slave: address filtering,
// quote and delimiter tracking, checksum check and ack generation.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  item      in   valid/ready   operation, rx_byte, ninth_bit, tx_busy
//  result    out  valid/ready   store/send valid and byte, listening, tx_empty
//  cfg       in   cfg_we        cfg_wdata = own_address
//
//  one word per cycle while the result is not stalled; a taken word passes
//  the input register, then the result register behind the step logic
//  a stalled result holds; one more word waits in the input register
//  arst_n clears state: listening, idle frame, own address 0xF5
// ----------------------------------------------------------------------------
`default_nettype none

module multidrop_receive_framer (
	input  wire logic    clk,
	input  wire logic    arst_n,
	mdrf_item_if.sink    item,
	mdrf_result_if.source result,
	input  wire logic    cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	mdrf_pkg::item_t   in_word;
	mdrf_pkg::item_t   word_s1;
	mdrf_pkg::result_t res_q;
	logic              valid_s1;
	logic              advance;
	logic              res_valid_q;

	assign in_word.operation = mdrf_pkg::op_t'(item.operation);
	assign in_word.rx_byte   = item.rx_byte;
	assign in_word.ninth_bit = item.ninth_bit;
	assign in_word.tx_busy   = item.tx_busy;

	mdrf_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.in_word  (in_word),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	mdrf_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.valid_s1    (valid_s1),
		.word_s1     (word_s1),
		.advance     (advance),
		.res_valid_q (res_valid_q),
		.res_ready   (result.ready),
		.res_q       (res_q)
	);

	assign result.valid       = res_valid_q;
	assign result.store_valid = res_q.store_valid;
	assign result.store_byte  = res_q.store_byte;
	assign result.send_valid  = res_q.send_valid;
	assign result.send_byte   = res_q.send_byte;
	assign result.listening   = res_q.listening;
	assign result.tx_empty    = res_q.tx_empty;

endmodule

`default_nettype wire

[rtl/core/mdrf_in_stage.sv]
// ----------------------------------------------------------------------------
// mdrf_in_stage
// Input register: captures one word per cycle while it is empty or the next stage advances.
// ----------------------------------------------------------------------------
`default_nettype none

module mdrf_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire mdrf_pkg::item_t in_word,
	input  wire logic           advance,
	output logic                valid_s1,
	output mdrf_pkg::item_t     word_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

endmodule

`default_nettype wire

[rtl/core/mdrf_core.sv]
// ----------------------------------------------------------------------------
// mdrf_core
// Framer state, per-word step logic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mdrf_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [7:0]      cfg_wdata,
	input  wire logic            valid_s1,
	input  wire mdrf_pkg::item_t word_s1,
	output logic                 advance,
	output logic                 res_valid_q,
	input  wire logic            res_ready,
	output mdrf_pkg::result_t    res_q
);

	logic [7:0]             own_address_q;
	logic                   listening_q, listening_d;
	mdrf_pkg::frame_state_t fs_q, fs_d;
	logic [7:0]             sum_q, sum_d;
	logic                   bcast_q, bcast_d;
	logic                   pending_q, pending_d;
	logic [7:0]             ack_q, ack_d;
	logic                   tx_free_q, tx_free_d;

	logic                   in_frame_rx;
	logic                   at_check;
	logic [7:0]             ack_new;
	logic [7:0]             data_c;
	mdrf_pkg::result_t      res_d;

	assign advance    = valid_s1 && (!res_valid_q || res_ready);

	assign in_frame_rx = (word_s1.operation == mdrf_pkg::OP_RX_BYTE) && !listening_q;
	assign at_check    = (fs_q == mdrf_pkg::FS_DELIM);
	assign ack_new     = ((sum_q & mdrf_pkg::SUM_MASK) == word_s1.rx_byte) ?
		mdrf_pkg::ACK_GOOD : mdrf_pkg::ACK_BAD;
	assign data_c      = at_check ? ack_new : word_s1.rx_byte;

	// next state
	always_comb begin
		listening_d = listening_q;
		fs_d        = fs_q;
		sum_d       = sum_q;
		bcast_d     = bcast_q;
		pending_d   = pending_q;
		ack_d       = ack_q;
		tx_free_d   = tx_free_q;
		unique case (word_s1.operation)
			mdrf_pkg::OP_RX_BYTE: begin
				if (listening_q) begin
					if (word_s1.ninth_bit && (word_s1.rx_byte == mdrf_pkg::BCAST_ADDR ||
						word_s1.rx_byte == own_address_q)) begin
						if (word_s1.rx_byte == mdrf_pkg::BCAST_ADDR) begin
							bcast_d = 1'b1;
						end
						listening_d = 1'b0;
						fs_d        = mdrf_pkg::FS_DATA;
						sum_d       = 8'h00;
					end
				end else begin
					if (at_check) begin
						listening_d = 1'b1;
						ack_d       = ack_new;
						if (!bcast_q) begin
							if (word_s1.tx_busy) begin
								pending_d = 1'b1;
							end else begin
								tx_free_d = 1'b0;
							end
						end else begin
							bcast_d = 1'b0;
						end
					end else if (word_s1.rx_byte == mdrf_pkg::QUOTE_CH) begin
						fs_d = mdrf_pkg::frame_state_t'(fs_q ^ mdrf_pkg::TOGGLE_Q);
					end else if (fs_q != mdrf_pkg::FS_QUOTED &&
						mdrf_pkg::is_delimiter(word_s1.rx_byte)) begin
						fs_d = mdrf_pkg::FS_DELIM;
					end
					sum_d = sum_q + data_c;
				end
			end
			mdrf_pkg::OP_TX_DONE: begin
				if (pending_q) begin
					pending_d = 1'b0;
				end else begin
					tx_free_d = 1'b1;
				end
			end
			mdrf_pkg::OP_HOST_TX: begin
				tx_free_d = 1'b0;
			end
			mdrf_pkg::OP_NOP: begin
			end
			default: begin
			end
		endcase
	end

	// result word
	always_comb begin
		res_d             = '0;
		res_d.listening   = listening_d;
		res_d.tx_empty    = tx_free_d;
		res_d.store_valid = in_frame_rx;
		res_d.store_byte  = in_frame_rx ? data_c : 8'h00;
		if (in_frame_rx && at_check && !bcast_q && !word_s1.tx_busy) begin
			res_d.send_valid = 1'b1;
			res_d.send_byte  = ack_new;
		end else if (word_s1.operation == mdrf_pkg::OP_TX_DONE && pending_q) begin
			res_d.send_valid = 1'b1;
			res_d.send_byte  = ack_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= mdrf_pkg::OWN_ADDR_RESET;
		end else if (cfg_we) begin
			own_address_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listening_q <= 1'b1;
			fs_q        <= mdrf_pkg::FS_IDLE;
			sum_q       <= 8'h00;
			bcast_q     <= 1'b0;
			pending_q   <= 1'b0;
			ack_q       <= 8'h00;
			tx_free_q   <= 1'b1;
		end else if (advance) begin
			listening_q <= listening_d;
			fs_q        <= fs_d;
			sum_q       <= sum_d;
			bcast_q     <= bcast_d;
			pending_q   <= pending_d;
			ack_q       <= ack_d;
			tx_free_q   <= tx_free_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/mdrf_checker.sv]
// ----------------------------------------------------------------------------
// mdrf_checker
// Port-level checks on result words of the framer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mdrf_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic store_valid,
	input wire logic [7:0] store_byte,
	input wire logic send_valid,
	input wire logic [7:0] send_byte,
	input wire logic listening
);

	a_store_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !store_valid |-> store_byte == 8'h00)
		else $error("store byte not zero without store");

	a_send_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && send_valid |->
		send_byte == mdrf_pkg::ACK_GOOD || send_byte == mdrf_pkg::ACK_BAD)
		else $error("sent byte is not an ack code");

	a_send_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !send_valid |-> send_byte == 8'h00)
		else $error("send byte not zero without send");

	a_ack_stored: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && send_valid && store_valid |->
		store_byte == send_byte && listening)
		else $error("immediate ack differs from stored code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(store_byte) &&
		$stable(send_byte) && $stable(send_valid))
		else $error("stalled result word changed");

endmodule

bind multidrop_receive_framer mdrf_checker u_mdrf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.store_valid (result.store_valid),
	.store_byte  (result.store_byte),
	.send_valid  (result.send_valid),
	.send_byte   (result.send_byte),
	.listening   (result.listening)
);

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multidrop receive framer. Address, data,
// quote, delimiter and checksum words are driven through the word channel
// under random idling and a long result hold-off. Every accepted word is
// run through an in-bench copy of the framer, and each result word is
// checked in every field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import mdrf_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_WORDS = 175;

	class ack_scoreboard;
		logic [7:0]   own_addr;
		logic         listening;
		logic         bcast;
		logic         ack_pend;
		logic         tx_free;
		frame_state_t fs;
		logic [7:0]   sum;
		logic [7:0]   ack;
		result_t      due_results[$];
		int           mismatches;

		function new();
			mismatches = 0;
			own_addr = OWN_ADDR_RESET;
			listening = 1'b1;
			bcast = 1'b0;
			ack_pend = 1'b0;
			tx_free = 1'b1;
			fs = FS_IDLE;
			sum = 8'h00;
			ack = 8'h00;
		endfunction

		static function bit is_terminator(logic [7:0] c);
			return c == CH_LF || c == CH_CR || c == CH_BANG ||
				c == CH_DOLL || c == CH_SEMI || c == CH_QMARK;
		endfunction

		function void note_word(item_t w);
			result_t    r;
			logic [7:0] c;
			r = '0;
			case (w.operation)
				OP_RX_BYTE: begin
					if (listening) begin
						if (w.ninth_bit && (w.rx_byte == BCAST_ADDR || w.rx_byte == own_addr)) begin
							if (w.rx_byte == BCAST_ADDR)
								bcast = 1'b1;
							listening = 1'b0;
							fs = FS_DATA;
							sum = 8'h00;
						end
					end else begin
						c = w.rx_byte;
						if (fs == FS_DELIM) begin
							listening = 1'b1;
							ack = ((sum & SUM_MASK) == c) ? ACK_GOOD : ACK_BAD;
							c = ack;
							if (!bcast) begin
								if (w.tx_busy) begin
									ack_pend = 1'b1;
								end else begin
									tx_free = 1'b0;
									r.send_valid = 1'b1;
									r.send_byte = ack;
								end
							end else begin
								bcast = 1'b0;
							end
						end else if (c == QUOTE_CH) begin
							fs = frame_state_t'(fs ^ TOGGLE_Q);
						end else if (fs != FS_QUOTED && is_terminator(c)) begin
							fs = FS_DELIM;
						end
						r.store_valid = 1'b1;
						r.store_byte = c;
						sum = sum + c;
					end
				end
				OP_TX_DONE: begin
					if (ack_pend) begin
						ack_pend = 1'b0;
						r.send_valid = 1'b1;
						r.send_byte = ack;
					end else begin
						tx_free = 1'b1;
					end
				end
				OP_HOST_TX: tx_free = 1'b0;
				default: ;
			endcase
			r.listening = listening;
			r.tx_empty = tx_free;
			due_results.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: store %0b/%02h send %0b/%02h listen %0b txe %0b",
						got.store_valid, got.store_byte, got.send_valid, got.send_byte,
						got.listening, got.tx_empty);
				return;
			end
			want = due_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected store %0b/%02h send %0b/%02h listen %0b txe %0b,",
						" got store %0b/%02h send %0b/%02h listen %0b txe %0b"},
						want.store_valid, want.store_byte, want.send_valid, want.send_byte,
						want.listening, want.tx_empty, got.store_valid, got.store_byte,
						got.send_valid, got.send_byte, got.listening, got.tx_empty);
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [7:0]    cfg_wdata;
	bit            idle_on;
	bit            hold_req;
	logic [7:0]    node_addr;
	int            words_sent;
	int            quiet;
	ack_scoreboard sb;

	mdrf_item_if   word_ch ();
	mdrf_result_if result_ch ();

	multidrop_receive_framer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (word_ch.sink),
		.result    (result_ch.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (word_ch.valid && word_ch.ready)
				sb.note_word('{op_t'(word_ch.operation), word_ch.rx_byte,
					word_ch.ninth_bit, word_ch.tx_busy});
			if (result_ch.valid && result_ch.ready)
				sb.check_result('{result_ch.store_valid, result_ch.store_byte,
					result_ch.send_valid, result_ch.send_byte, result_ch.listening,
					result_ch.tx_empty});
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (word_ch.valid && word_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("FAIL multidrop_receive_framer");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin : result_side
		int stall;
		int hold;
		stall = 0;
		hold = 0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold = 40;
			end
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				result_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 3) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic offer_word(input op_t op, input logic [7:0] b, input logic nb,
		input logic busy);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			word_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		word_ch.valid <= 1'b1;
		word_ch.operation <= op;
		word_ch.rx_byte <= b;
		word_ch.ninth_bit <= nb;
		word_ch.tx_busy <= busy;
		do @(posedge clk); while (!word_ch.ready);
		words_sent++;
	endtask

	task automatic rx_word(input logic [7:0] b, input logic nb, input logic busy);
		offer_word(OP_RX_BYTE, b, nb, busy);
	endtask

	task automatic wait_for_drain();
		word_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_address(input logic [7:0] a);
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.own_addr = a;
		node_addr = a;
		@(posedge clk);
	endtask

	task automatic random_word();
		offer_word(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic maybe_side_op();
		if ($urandom_range(0, 5) == 0)
			offer_word(op_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	function automatic logic [7:0] pick_delimiter();
		case ($urandom_range(0, 5))
			0: return CH_LF;
			1: return CH_CR;
			2: return CH_BANG;
			3: return CH_DOLL;
			4: return CH_SEMI;
			default: return CH_QMARK;
		endcase
	endfunction

	function automatic logic [7:0] pick_text_byte();
		case ($urandom_range(0, 9))
			0: return QUOTE_CH;
			1: return pick_delimiter();
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// address, body, delimiter, checksum; side operations mixed in
	task automatic send_frame(input bit to_all);
		logic [7:0] total;
		logic [7:0] b;
		logic [7:0] ck;
		bit         quoted;
		bit         closed;
		int         n;
		total = 8'h00;
		quoted = 1'b0;
		closed = 1'b0;
		n = $urandom_range(0, 10);
		rx_word(to_all ? BCAST_ADDR : node_addr, 1'b1, 1'($urandom_range(0, 1)));
		for (int i = 0; i < n && !closed; i++) begin
			maybe_side_op();
			b = pick_text_byte();
			rx_word(b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			total = total + b;
			if (b == QUOTE_CH)
				quoted = !quoted;
			else if (!quoted && ack_scoreboard::is_terminator(b))
				closed = 1'b1;
		end
		if (!closed) begin
			if (quoted) begin
				rx_word(QUOTE_CH, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				total = total + QUOTE_CH;
			end
			b = pick_delimiter();
			rx_word(b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			total = total + b;
		end
		maybe_side_op();
		ck = ($urandom_range(0, 3) != 0) ? (total & SUM_MASK) : 8'($urandom_range(0, 255));
		rx_word(ck, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		maybe_side_op();
	endtask

	task automatic random_phase(input int count);
		int target;
		int r;
		target = words_sent + count;
		while (words_sent < target) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				send_frame(1'b0);
			else if (r < 8)
				send_frame(1'b1);
			else
				repeat ($urandom_range(1, 4)) random_word();
		end
	endtask

	initial begin : stimulus
		logic [7:0] addr_plan [6];
		sb = new();
		word_ch.valid <= 1'b0;
		word_ch.operation <= OP_NOP;
		word_ch.rx_byte <= 8'h00;
		word_ch.ninth_bit <= 1'b0;
		word_ch.tx_busy <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 8'h00;
		arst_n <= 1'b0;
		quiet = 0;
		words_sent = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		node_addr = OWN_ADDR_RESET;
		addr_plan = '{8'h00, 8'hFF, BCAST_ADDR, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), OWN_ADDR_RESET};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain byte and foreign address while listening
		rx_word(OWN_ADDR_RESET, 1'b0, 1'b0);
		rx_word(8'hF4, 1'b1, 1'b1);
		// own frame, quoted delimiter, ack sent at once
		rx_word(OWN_ADDR_RESET, 1'b1, 1'b0);
		rx_word(8'h00, 1'b1, 1'b0);
		rx_word(8'hFF, 1'b0, 1'b1);
		rx_word(QUOTE_CH, 1'b0, 1'b0);
		rx_word(CH_SEMI, 1'b0, 1'b0);
		rx_word(QUOTE_CH, 1'b0, 1'b0);
		rx_word(CH_LF, 1'b0, 1'b0);
		rx_word(8'h08, 1'b0, 1'b0);
		offer_word(OP_HOST_TX, 8'h00, 1'b0, 1'b0);
		offer_word(OP_TX_DONE, 8'h00, 1'b0, 1'b0);
		offer_word(OP_NOP, 8'hFF, 1'b1, 1'b1);
		// broadcast frame, no ack
		rx_word(BCAST_ADDR, 1'b1, 1'b0);
		rx_word(8'h41, 1'b0, 1'b0);
		rx_word(CH_DOLL, 1'b0, 1'b0);
		rx_word(8'h65, 1'b0, 1'b1);
		// bad ack held pending, then replaced by a good one
		rx_word(OWN_ADDR_RESET, 1'b1, 1'b0);
		rx_word(CH_QMARK, 1'b0, 1'b0);
		rx_word(8'h00, 1'b0, 1'b1);
		rx_word(OWN_ADDR_RESET, 1'b1, 1'b0);
		rx_word(CH_CR, 1'b0, 1'b0);
		rx_word(CH_CR, 1'b0, 1'b1);
		offer_word(OP_TX_DONE, 8'h00, 1'b0, 1'b0);
		offer_word(OP_TX_DONE, 8'h00, 1'b0, 1'b0);

		for (int i = 0; i < 6; i++) begin
			wait_for_drain();
			set_address(addr_plan[i]);
			if (i == 1)
				hold_req = 1'b1;
			if (i == 5)
				idle_on = 1'b0;
			random_phase(PHASE_WORDS);
		end

		wait_for_drain();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.due_results.size() == 0)
			$display("PASS multidrop_receive_framer");
		else
			$display("FAIL multidrop_receive_framer");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/mdrf_pkg.sv
rtl/core/mdrf_if.sv
rtl/core/mdrf_in_stage.sv
rtl/core/mdrf_core.sv
rtl/core/multidrop_receive_framer.sv
rtl/core/mdrf_checker.sv
dv/tb_top.sv
